// ===== rtl/rsz_pkg.sv =====
// Package for the bilinear image resizer: limits, codes, request and result types.
// Used by every file under rtl; depends on nothing.
`default_nettype none
package rsz_pkg;

  localparam int MAX_SRC_SIDE = 128;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_DST_SIDE = 1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SIZE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CHANNELS   = 3'd2;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [15:0] write_address;
    logic [7:0]  write_value;
    logic [9:0]  dst_x;
    logic [9:0]  dst_y;
    logic [1:0]  channel;
  } rsz_in_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [1:0] status;
  } rsz_out_t;

  typedef struct packed {
    logic [7:0]  src_width;
    logic [7:0]  src_height;
    logic [2:0]  channel_count;
    logic [10:0] dst_width;
    logic [10:0] dst_height;
  } rsz_cfg_t;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  value;
    logic [1:0]  status;
    logic [16:0] nx;
    logic [16:0] ny;
    logic [1:0]  ch;
  } rsz_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/rsz_front.sv =====
// Front end: classifies an incoming request (write, bad size, out of range, read)
// and scales the destination coordinate. Depends on rsz_pkg.
`default_nettype none
module rsz_front import rsz_pkg::*; (
  input  rsz_in_t  in_data,
  input  rsz_cfg_t cfg,
  output rsz_cmd_t cmd
);

  logic size_bad;
  logic range_bad;

  always_comb begin
    size_bad = (cfg.src_width == 8'd0) || (cfg.src_height == 8'd0) ||
               (cfg.channel_count == 3'd0) || (cfg.dst_width == 11'd0) ||
               (cfg.dst_height == 11'd0) ||
               (cfg.src_width > 8'(MAX_SRC_SIDE)) || (cfg.src_height > 8'(MAX_SRC_SIDE)) ||
               (cfg.channel_count > 3'(MAX_CHANNELS)) ||
               (cfg.dst_width > 11'(MAX_DST_SIDE)) || (cfg.dst_height > 11'(MAX_DST_SIDE));
    range_bad = ({1'b0, in_data.dst_x} >= cfg.dst_width) ||
                ({1'b0, in_data.dst_y} >= cfg.dst_height) ||
                ({1'b0, in_data.channel} >= cfg.channel_count);

    cmd.op    = in_data.operation;
    cmd.addr  = in_data.write_address;
    cmd.value = in_data.write_value;
    cmd.ch    = in_data.channel;
    cmd.nx    = 17'(in_data.dst_x) * 17'(cfg.src_width - 8'd1);
    cmd.ny    = 17'(in_data.dst_y) * 17'(cfg.src_height - 8'd1);
    if (size_bad) begin
      cmd.status = ST_SIZE;
    end else if (range_bad) begin
      cmd.status = ST_RANGE;
    end else begin
      cmd.status = ST_OK;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rsz_fifo.sv =====
// Short request queue between front end and back end.
// Depends on rsz_pkg.
`default_nettype none
module rsz_fifo import rsz_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rsz_cmd_t            din,
  input  logic                pop,
  output rsz_cmd_t            dout,
  output logic                full,
  output logic                empty,
  output logic [QUEUE_AW:0]   level
);

  rsz_cmd_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW:0]     level_r;

  assign full  = (level_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (level_r == '0);
  assign level = level_r;
  assign dout  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rsz_back.sv =====
// Back end: sample store, coordinate dividers, four-tap blend and rounding divider.
// Depends on rsz_pkg.
`default_nettype none
module rsz_back import rsz_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rsz_cfg_t cfg,
  input  rsz_cmd_t head,
  input  logic     empty,
  output logic     pop,
  output logic     out_valid,
  output rsz_out_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_ROW   = 5'b00100,
    S_FETCH = 5'b01000,
    S_NORM  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  mem [65536];
  logic        mem_we;

  logic [2:0]  cnt_r;
  logic [1:0]  ch_r;
  logic [9:0]  dx, dy;
  logic [9:0]  xrem_r, yrem_r;
  logic [6:0]  xlow_r, ylow_r;
  logic [6:0]  xq_r, yq_r;
  logic [10:0] xtry, ytry;
  logic [6:0]  x1_r;
  logic [14:0] row0_r, row1_r;
  logic [19:0] den_r;
  logic [6:0]  x1_c, y1_c;

  logic [1:0]  k;
  logic [6:0]  px;
  logic [14:0] row;
  logic [9:0]  wxs, wys;
  logic [15:0] raddr_r;
  logic [19:0] w_r, w2_r;
  logic        va_r, vb_r;
  logic [7:0]  rd_r;
  logic [27:0] acc_r;
  logic [28:0] num;

  logic [20:0] frem_r;
  logic [7:0]  flow_r;
  logic [7:0]  fq_r;
  logic [21:0] ftry;
  logic [20:0] fden;
  logic        fbit;
  logic [7:0]  fq_nxt;

  logic        out_valid_r;
  rsz_out_t    out_data_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    dx = (cfg.dst_width > 11'd1) ? 10'(cfg.dst_width - 11'd1) : 10'd1;
    dy = (cfg.dst_height > 11'd1) ? 10'(cfg.dst_height - 11'd1) : 10'd1;
    xtry = {xrem_r, xlow_r[6]};
    ytry = {yrem_r, ylow_r[6]};
    x1_c = (8'(xq_r) + 8'd1 < cfg.src_width) ? xq_r + 7'd1 : 7'(cfg.src_width - 8'd1);
    y1_c = (8'(yq_r) + 8'd1 < cfg.src_height) ? yq_r + 7'd1 : 7'(cfg.src_height - 8'd1);
    k   = cnt_r[1:0];
    px  = k[0] ? x1_r : xq_r;
    row = k[1] ? row1_r : row0_r;
    wxs = k[0] ? xrem_r : dx - xrem_r;
    wys = k[1] ? yrem_r : dy - yrem_r;
    num = {acc_r, 1'b0} + 29'(den_r);
    fden = {den_r, 1'b0};
    ftry = {frem_r, flow_r[7]};
    fbit = (ftry >= {1'b0, fden});
    fq_nxt = {fq_r[6:0], fbit};
  end

  always_comb begin
    pop       = (state_r == S_IDLE) && !empty;
    mem_we    = pop && (head.op == OP_WRITE);
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop && head.op == OP_READ && head.status == ST_OK) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == 3'd6) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: state_nxt = S_FETCH;
      S_FETCH: begin
        if (cnt_r == 3'd6) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (cnt_r == 3'd7) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.addr] <= head.value;
    end
    rd_r <= mem[raddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      va_r        <= (state_r == S_FETCH) && (cnt_r < 3'd4);
      vb_r        <= va_r;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (pop && head.op == OP_READ && head.status != ST_OK) begin
            out_valid_r <= 1'b1;
          end
        end
        S_DIV: cnt_r <= (cnt_r == 3'd6) ? 3'd0 : cnt_r + 3'd1;
        S_ROW: cnt_r <= '0;
        S_FETCH: cnt_r <= (cnt_r == 3'd6) ? 3'd0 : cnt_r + 3'd1;
        S_NORM: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            out_valid_r <= 1'b1;
          end
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    w2_r <= w_r;
    if (vb_r) begin
      acc_r <= acc_r + 28'(w2_r) * 28'(rd_r);
    end
    case (state_r)
      S_IDLE: begin
        xrem_r <= head.nx[16:7];
        xlow_r <= head.nx[6:0];
        yrem_r <= head.ny[16:7];
        ylow_r <= head.ny[6:0];
        ch_r   <= head.ch;
        den_r  <= dx * dy;
        acc_r  <= '0;
        out_data_r.pixel_value <= 8'd0;
        out_data_r.status      <= head.status;
      end
      S_DIV: begin
        xlow_r <= {xlow_r[5:0], 1'b0};
        ylow_r <= {ylow_r[5:0], 1'b0};
        if (xtry >= {1'b0, dx}) begin
          xrem_r <= 10'(xtry - {1'b0, dx});
          xq_r   <= {xq_r[5:0], 1'b1};
        end else begin
          xrem_r <= xtry[9:0];
          xq_r   <= {xq_r[5:0], 1'b0};
        end
        if (ytry >= {1'b0, dy}) begin
          yrem_r <= 10'(ytry - {1'b0, dy});
          yq_r   <= {yq_r[5:0], 1'b1};
        end else begin
          yrem_r <= ytry[9:0];
          yq_r   <= {yq_r[5:0], 1'b0};
        end
      end
      S_ROW: begin
        x1_r   <= x1_c;
        row0_r <= 15'(yq_r) * 15'(cfg.src_width);
        row1_r <= 15'(y1_c) * 15'(cfg.src_width);
      end
      S_FETCH: begin
        raddr_r <= 16'((18'(row) + 18'(px)) * 18'(cfg.channel_count) + 18'(ch_r));
        w_r     <= wxs * wys;
        if (cnt_r == 3'd6) begin
          frem_r <= num[28:8];
          flow_r <= num[7:0];
        end
      end
      S_NORM: begin
        flow_r <= {flow_r[6:0], 1'b0};
        fq_r   <= fq_nxt;
        frem_r <= fbit ? 21'(ftry - {1'b0, fden}) : ftry[20:0];
        if (cnt_r == 3'd7) begin
          out_data_r.pixel_value <= fq_nxt;
          out_data_r.status      <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bilinear_image_resizer.sv =====
// Top level of the bilinear image resizer: configuration registers, front end,
// request queue and back end. Depends on rsz_pkg, rsz_front, rsz_fifo, rsz_back.
//
//   channel  ports                           handshake
//   input    start, busy, in_data            taken when start && !busy
//   result   out_valid, out_data             one-cycle strobe, no back-pressure
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data   taken when valid && ready
//
// A write request is handled in the idle state, as is a read that fails the size or
// range check; a valid read runs through the 7-step coordinate divider, the four
// fetches from the sample store and the 8-step rounding divider. A four-deep queue
// lets the input side keep taking requests; busy rises when it is full. Reset is
// synchronous and clears control state only; the sample store is not cleared.
`default_nettype none
module bilinear_image_resizer import rsz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rsz_in_t     in_data,
  output logic        out_valid,
  output rsz_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  rsz_cfg_t          cfg_r;
  rsz_cmd_t          front_cmd;
  rsz_cmd_t          head;
  logic              full, empty, pop, push;
  logic [QUEUE_AW:0] level;

  assign cfg_ready = 1'b1;
  assign busy      = full;
  assign push      = start && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width     <= 8'd1;
      cfg_r.src_height    <= 8'd1;
      cfg_r.channel_count <= 3'd1;
      cfg_r.dst_width     <= 11'd1;
      cfg_r.dst_height    <= 11'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH:  cfg_r.src_width     <= cfg_data[7:0];
        REG_SRC_HEIGHT: cfg_r.src_height    <= cfg_data[7:0];
        REG_CHANNELS:   cfg_r.channel_count <= cfg_data[2:0];
        REG_DST_WIDTH:  cfg_r.dst_width     <= cfg_data;
        REG_DST_HEIGHT: cfg_r.dst_height    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rsz_front u_front (
    .in_data (in_data),
    .cfg     (cfg_r),
    .cmd     (front_cmd)
  );

  rsz_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_cmd),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty),
    .level (level)
  );

  rsz_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.pixel_value == 8'd0)
    else $error("failed result carries a nonzero sample");

  a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> level != '0)
    else $error("accepted request missing from queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue popped while empty");

endmodule
`default_nettype wire
